// ----- hdl/mhde_pkg.sv -----
// Shared constants, tables and types of the MP3 header duration estimator.
package mhde_pkg;

  localparam int WINDOW_BYTES = 2048;
  localparam int CAP_DEPTH    = 54;
  localparam int SEEN_W       = $clog2(WINDOW_BYTES + 1);
  localparam int OFF_W        = $clog2(CAP_DEPTH + 1);

  localparam int FRAMES_W = 32;
  localparam int SPF_MS_W = 21;
  localparam int DIV_W    = FRAMES_W + SPF_MS_W;   // dividend / quotient width
  localparam int DVS_W    = 16;                    // divisor width
  localparam int DCNT_W   = $clog2(DIV_W);

  localparam logic [SPF_MS_W-1:0] SPF_MS_MPEG1 = 21'd1152000;  // 1152 * 1000
  localparam logic [SPF_MS_W-1:0] SPF_MS_MPEG2 = 21'd576000;   // 576 * 1000

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [2:0] SYNC_TOP  = 3'b111;
  localparam logic [1:0] VER_RSVD  = 2'b01;
  localparam logic [1:0] VER_MPEG1 = 2'b11;
  localparam logic [1:0] VER_MPEG2 = 2'b10;
  localparam logic [1:0] LAYER_3   = 2'b01;
  localparam logic [1:0] CH_MONO   = 2'b11;

  localparam logic [31:0] TAG_XING = 32'h5869_6E67;
  localparam logic [31:0] TAG_INFO = 32'h496E_666F;
  localparam logic [31:0] TAG_VBRI = 32'h5642_5249;

  localparam logic [OFF_W-1:0] VBRI_OFF    = 6'd36;
  localparam logic [OFF_W-1:0] XOFF_M1_ST  = 6'd36;
  localparam logic [OFF_W-1:0] XOFF_M1_MO  = 6'd21;
  localparam logic [OFF_W-1:0] XOFF_M2_ST  = 6'd21;
  localparam logic [OFF_W-1:0] XOFF_M2_MO  = 6'd13;

  localparam logic [8:0] BR_MPEG1 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] BR_MPEG2 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
  localparam logic [DVS_W-1:0] SR_MPEG1  [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};
  localparam logic [DVS_W-1:0] SR_MPEG2  [4] = '{16'd22050, 16'd24000, 16'd16000, 16'd0};
  localparam logic [DVS_W-1:0] SR_MPEG25 [4] = '{16'd11025, 16'd12000, 16'd8000, 16'd0};

  localparam logic REG_FILE_SIZE   = 1'b0;
  localparam logic REG_AUDIO_START = 1'b1;

  typedef enum logic [1:0] {
    METH_NONE = 2'd0,
    METH_XING = 2'd1,
    METH_VBRI = 2'd2,
    METH_CBR  = 2'd3
  } meth_t;

  // controller -> datapath
  typedef struct packed {
    logic scan_en;
    logic eval;
    logic div_start;
    logic out_load;
    logic clear;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic zero_res;
    logic div_done;
    logic div_busy;
  } sts_t;

endpackage

// ----- hdl/mhde_div.sv -----
// Restoring divider, one quotient bit per cycle.
module mhde_div
  import mhde_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W:0]    rem_sh;
  logic              fits;

  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};
  assign done   = busy_r && (cnt_r == DCNT_W'(DIV_W - 1));

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the difference fits DVS_W bits
      rem_nxt = fits ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (done) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ----- hdl/mhde_dp.sv -----
// Datapath: config registers, sync scan, header/tag capture, operand setup, divider.
module mhde_dp
  import mhde_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [7:0]  in_byte,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [31:0] out_dur,
  output meth_t       out_meth
);

  // config
  logic [31:0] fsize_r, fsize_nxt;
  logic [31:0] astart_r, astart_nxt;

  // scan control
  logic [7:0]       prev_r, prev_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic             sync_r, sync_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic             xvalid_r, xvalid_nxt;
  logic             vvalid_r, vvalid_nxt;

  // captured fields
  logic [7:0]  hdr1_r, hdr1_nxt;
  logic [7:0]  hdr2_r, hdr2_nxt;
  logic [7:0]  hdr3_r, hdr3_nxt;
  logic [31:0] win_r, win_nxt;      // last four captured bytes
  logic        xmagic_r, xmagic_nxt;
  logic        xflag_r, xflag_nxt;
  logic [31:0] xframes_r, xframes_nxt;
  logic        vmagic_r, vmagic_nxt;
  logic [31:0] vframes_r, vframes_nxt;

  // result
  meth_t       meth_r, meth_nxt;
  meth_t       ometh_r, ometh_nxt;  // method of the word on the output
  logic [31:0] dur_r, dur_nxt;

  logic [OFF_W-1:0] xoff;
  logic             mpeg1, mono, in_win, sync_hit;
  logic [31:0]      win_sh;

  logic             size_ok, hdr_ok, tbl_ok, use_x, use_v;
  logic [8:0]       bitrate;
  logic [DVS_W-1:0] srate;
  meth_t            meth_sel;
  logic [FRAMES_W-1:0] frames;
  logic [SPF_MS_W-1:0] spf_ms;
  logic [DIV_W-1:0] dividend;
  logic [DVS_W-1:0] divisor;
  logic [31:0]      audio_len;

  logic             div_busy, div_done;
  logic [DIV_W-1:0] quotient;

  assign mpeg1    = hdr1_r[4:3] == VER_MPEG1;
  assign mono     = hdr3_r[7:6] == CH_MONO;
  assign xoff     = mpeg1 ? (mono ? XOFF_M1_MO : XOFF_M1_ST) : (mono ? XOFF_M2_MO : XOFF_M2_ST);
  assign in_win   = seen_r < SEEN_W'(WINDOW_BYTES);
  assign win_sh   = {win_r[23:0], in_byte};
  assign sync_hit = (seen_r != '0) && (prev_r == SYNC_BYTE) && (in_byte[7:5] == SYNC_TOP) &&
                    (in_byte[4:3] != VER_RSVD) && (in_byte[2:1] == LAYER_3);

  always_comb begin
    fsize_nxt   = fsize_r;
    astart_nxt  = astart_r;
    prev_nxt    = prev_r;
    seen_nxt    = seen_r;
    sync_nxt    = sync_r;
    off_nxt     = off_r;
    xvalid_nxt  = xvalid_r;
    vvalid_nxt  = vvalid_r;
    hdr1_nxt    = hdr1_r;
    hdr2_nxt    = hdr2_r;
    hdr3_nxt    = hdr3_r;
    win_nxt     = win_r;
    xmagic_nxt  = xmagic_r;
    xflag_nxt   = xflag_r;
    xframes_nxt = xframes_r;
    vmagic_nxt  = vmagic_r;
    vframes_nxt = vframes_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_FILE_SIZE:   fsize_nxt  = cfg_data;
        REG_AUDIO_START: astart_nxt = cfg_data;
        default:         fsize_nxt  = fsize_r;
      endcase
    end

    if (cmd.clear) begin
      prev_nxt   = '0;
      seen_nxt   = '0;
      sync_nxt   = 1'b0;
      off_nxt    = '0;
      xvalid_nxt = 1'b0;
      vvalid_nxt = 1'b0;
    end else if (cmd.scan_en && in_win) begin
      if (sync_r) begin
        if (off_r < OFF_W'(CAP_DEPTH)) begin
          // off_r is the frame position of this byte
          win_nxt = win_sh;
          off_nxt = off_r + 1'b1;
          if (off_r == OFF_W'(2)) hdr2_nxt = in_byte;
          if (off_r == OFF_W'(3)) hdr3_nxt = in_byte;
          if (off_r == xoff + OFF_W'(3))
            xmagic_nxt = (win_sh == TAG_XING) || (win_sh == TAG_INFO);
          if (off_r == xoff + OFF_W'(7)) xflag_nxt = in_byte[0];
          if (off_r == xoff + OFF_W'(11)) begin
            xframes_nxt = win_sh;
            xvalid_nxt  = 1'b1;
          end
          if (off_r == VBRI_OFF + OFF_W'(3)) vmagic_nxt = win_sh == TAG_VBRI;
          if (off_r == VBRI_OFF + OFF_W'(17)) begin
            vframes_nxt = win_sh;
            vvalid_nxt  = 1'b1;
          end
        end
      end else if (sync_hit) begin
        sync_nxt = 1'b1;
        hdr1_nxt = in_byte;
        off_nxt  = OFF_W'(2);
        win_nxt  = {16'h0000, SYNC_BYTE, in_byte};
      end
      prev_nxt = in_byte;
      seen_nxt = seen_r + 1'b1;
    end
  end

  // operand selection for the final estimate
  assign size_ok = (fsize_r != '0) && (fsize_r != '1) && (astart_r < fsize_r);
  assign hdr_ok  = (seen_r >= SEEN_W'(4)) && sync_r && (off_r >= OFF_W'(4));

  always_comb begin
    unique case (hdr1_r[4:3])
      VER_MPEG1: begin
        bitrate = BR_MPEG1[hdr2_r[7:4]];
        srate   = SR_MPEG1[hdr2_r[3:2]];
      end
      VER_MPEG2: begin
        bitrate = BR_MPEG2[hdr2_r[7:4]];
        srate   = SR_MPEG2[hdr2_r[3:2]];
      end
      default: begin
        bitrate = BR_MPEG2[hdr2_r[7:4]];
        srate   = SR_MPEG25[hdr2_r[3:2]];
      end
    endcase
  end

  assign tbl_ok = (bitrate != '0) && (srate != '0);
  assign use_x  = xvalid_r && xmagic_r && xflag_r && (xframes_r != '0);
  assign use_v  = vvalid_r && vmagic_r && (vframes_r != '0);

  always_comb begin
    if (!(size_ok && hdr_ok && tbl_ok)) meth_sel = METH_NONE;
    else if (use_x)                     meth_sel = METH_XING;
    else if (use_v)                     meth_sel = METH_VBRI;
    else                                meth_sel = METH_CBR;
  end

  assign frames    = use_x ? xframes_r : vframes_r;
  assign spf_ms    = mpeg1 ? SPF_MS_MPEG1 : SPF_MS_MPEG2;
  assign audio_len = fsize_r - astart_r;
  assign dividend  = (meth_sel == METH_CBR) ? DIV_W'({audio_len, 3'b000}) :
                     DIV_W'(frames) * DIV_W'(spf_ms);
  assign divisor   = (meth_sel == METH_CBR) ? DVS_W'(bitrate) : srate;

  always_comb begin
    meth_nxt  = meth_r;
    ometh_nxt = ometh_r;
    dur_nxt   = dur_r;
    if (cmd.eval) meth_nxt = meth_sel;
    if (cmd.out_load) begin
      dur_nxt   = (meth_r == METH_NONE) ? '0 : quotient[31:0];
      ometh_nxt = meth_r;
    end
  end

  mhde_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsize_r  <= '0;
      astart_r <= '0;
      prev_r   <= '0;
      seen_r   <= '0;
      sync_r   <= 1'b0;
      off_r    <= '0;
      xvalid_r <= 1'b0;
      vvalid_r <= 1'b0;
    end else begin
      fsize_r  <= fsize_nxt;
      astart_r <= astart_nxt;
      prev_r   <= prev_nxt;
      seen_r   <= seen_nxt;
      sync_r   <= sync_nxt;
      off_r    <= off_nxt;
      xvalid_r <= xvalid_nxt;
      vvalid_r <= vvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr1_r    <= hdr1_nxt;
    hdr2_r    <= hdr2_nxt;
    hdr3_r    <= hdr3_nxt;
    win_r     <= win_nxt;
    xmagic_r  <= xmagic_nxt;
    xflag_r   <= xflag_nxt;
    xframes_r <= xframes_nxt;
    vmagic_r  <= vmagic_nxt;
    vframes_r <= vframes_nxt;
    meth_r    <= meth_nxt;
    ometh_r   <= ometh_nxt;
    dur_r     <= dur_nxt;
  end

  assign sts.zero_res = meth_sel == METH_NONE;
  assign sts.div_done = div_done;
  assign sts.div_busy = div_busy;
  assign out_dur      = dur_r;
  assign out_meth     = ometh_r;

endmodule

// ----- hdl/mhde_ctrl.sv -----
// Control state machine: byte intake, estimate sequencing, result handoff.
module mhde_ctrl
  import mhde_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = state_r == S_IDLE;

  assign cmd.scan_en   = in_valid && in_ready;
  assign cmd.eval      = state_r == S_EVAL;
  assign cmd.div_start = (state_r == S_EVAL) && !sts.zero_res;
  assign cmd.out_load  = (state_r == S_FINISH) && slot_free;
  assign cmd.clear     = cmd.out_load;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE:   if (in_valid && in_last) state_nxt = S_EVAL;
      S_EVAL:   state_nxt = sts.zero_res ? S_FINISH : S_DIV;
      S_DIV:    if (sts.div_done) state_nxt = S_FINISH;
      S_FINISH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/mp3_header_duration_estimator_unit.sv -----
// MP3 header duration estimator: scans audio bytes, gives play time in ms.
// Bytes not marked last are taken back to back.
// After the last byte: a setup state with the operand multiply, the divider (skipped when no
// estimate applies), then a handoff state that waits for a free output register.
// Results sit in an output register; bytes of the next file are taken while it waits.
// Synchronous active-low reset clears the scan state and both config registers.
module mp3_header_duration_estimator_unit
  import mhde_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] duration_ms
  output logic [1:0]  out_tuser    // [1:0] method
);

  cmd_t  cmd;
  sts_t  sts;
  meth_t meth;

  assign cfg_ready = 1'b1;

  mhde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  mhde_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_dur   (out_tdata),
    .out_meth  (meth)
  );

  assign out_tuser = meth;

  // no bytes taken once the last one is in, until the result is handed off
  a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("byte accepted during estimate");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_busy |-> !in_tready)
    else $error("input open while divider runs");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_tvalid) && (out_tuser == METH_NONE)) |-> (out_tdata == '0))
    else $error("nonzero duration without method");

  a_div_ends_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |=> (cmd.out_load || (out_tvalid && !out_tready)))
    else $error("divider finished without result handoff");

endmodule
